>>> rtl/bffa_pkg.sv
// Shared constants, codes and control types of the bitmap first-free allocator.
package bffa_pkg;

  localparam int unsigned INODE_BITS  = 1024;
  localparam int unsigned DATA_BITS   = 8192;
  localparam int unsigned WORD_BITS   = 32;
  localparam int unsigned INODE_WORDS = (INODE_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned DATA_WORDS  = (DATA_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned RAM_DEPTH   = INODE_WORDS + DATA_WORDS;
  localparam int unsigned RAM_AW      = $clog2(RAM_DEPTH);
  localparam int unsigned BIT_W       = $clog2(WORD_BITS);
  localparam int unsigned WCNT_W      = $clog2(DATA_WORDS + 1);

  localparam int unsigned IDX_W      = 13;
  localparam int unsigned LIM_W      = 14;
  localparam int unsigned IREG_W     = 11;
  localparam int unsigned DREG_W     = 14;
  localparam int unsigned CFG_W      = 14;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned TDATA_W    = 16;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_USER_W = 2;

  localparam int unsigned TU_FUNC = 0;
  localparam int unsigned TU_SEL  = 1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_MARK  = 1'b1;
  localparam logic MAP_INODE  = 1'b0;
  localparam logic MAP_DATA   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_INODE_BITS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_BITS  = 1'b1;

  typedef struct packed {
    logic clear_run;
    logic capture;
    logic mark_rd;
    logic mark_wr;
    logic scan_run;
    logic pend_range;
    logic pend_full;
    logic publish;
  } bffa_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic is_mark;
    logic idx_ok;
    logic lim_zero;
    logic scan_done;
    logic out_free;
  } bffa_stat_t;

endpackage

>>> rtl/bffa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bffa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/bffa_ctrl.sv
// Sequencing state machine of the bitmap first-free allocator.
module bffa_ctrl
  import bffa_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  bffa_stat_t stat_i,
  output bffa_cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_MUPD  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;
  localparam logic [2:0] S_CLEAR = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear_run = 1'b1;
        if (stat_i.clear_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat_i.is_mark) begin
          if (stat_i.idx_ok) begin
            cmd_o.mark_rd = 1'b1;
            state_d       = S_MUPD;
          end else begin
            cmd_o.pend_range = 1'b1;
            state_d          = S_RESP;
          end
        end else if (stat_i.lim_zero) begin
          cmd_o.pend_full = 1'b1;
          state_d         = S_RESP;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_MUPD: begin
        cmd_o.mark_wr = 1'b1;
        state_d       = S_RESP;
      end
      S_SCAN: begin
        cmd_o.scan_run = 1'b1;
        if (stat_i.scan_done) begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.publish = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/bffa_datapath.sv
// Bitmap storage, word scan, limit checks and result register of the allocator.
module bffa_datapath
  import bffa_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_W-1:0]       cfg_data_i,
  input  logic [TDATA_W-1:0]     in_data_i,
  input  logic [IN_USER_W-1:0]   in_user_i,
  input  bffa_cmd_t              cmd_i,
  output bffa_stat_t             stat_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [TDATA_W-1:0]     out_data_o,
  output logic [OUT_USER_W-1:0]  out_user_o
);

  function automatic logic [RAM_AW-1:0] phys_addr(input logic sel,
                                                  input logic [WCNT_W-1:0] w);
    logic [RAM_AW-1:0] a;
    a = RAM_AW'(w);
    if (sel == MAP_DATA) begin
      a = RAM_AW'(INODE_WORDS) + RAM_AW'(w);
    end
    return a;
  endfunction

  logic [IREG_W-1:0]    inode_used_q;
  logic [DREG_W-1:0]    data_used_q;
  logic                 req_func_q;
  logic                 req_sel_q;
  logic [IDX_W-1:0]     req_idx_q;
  logic [WCNT_W-1:0]    rd_w_q;
  logic [WCNT_W-1:0]    eval_w_q;
  logic                 eval_v_q;
  logic [RAM_AW-1:0]    clr_w_q;
  logic [STATUS_W-1:0]  pend_st_q;
  logic [IDX_W-1:0]     pend_idx_q;
  logic                 out_valid_q;
  logic [STATUS_W-1:0]  out_st_q;
  logic [IDX_W-1:0]     out_idx_q;

  logic [LIM_W-1:0]     lim;
  logic [LIM_W-1:0]     lim_rnd;
  logic [WCNT_W-1:0]    nwords;
  logic [WCNT_W-1:0]    mark_w;
  logic [WORD_BITS-1:0] word_eff;
  logic [WORD_BITS-1:0] ram_rdata;
  logic [LIM_W-1:0]     base;
  logic [LIM_W-1:0]     rem;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] free_bits;
  logic                 found;
  logic [BIT_W-1:0]     pos;
  logic [LIM_W-1:0]     found_full;
  logic                 eval_last;
  logic                 scan_hit;
  logic                 scan_miss;
  logic                 issue;
  logic                 ram_we;
  logic [RAM_AW-1:0]    ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic                 ram_re;
  logic [RAM_AW-1:0]    ram_raddr;
  logic                 out_free;

  always_comb begin
    if (req_sel_q == MAP_DATA) begin
      lim = (LIM_W'(data_used_q) < LIM_W'(DATA_BITS)) ? LIM_W'(data_used_q)
                                                       : LIM_W'(DATA_BITS);
    end else begin
      lim = (LIM_W'(inode_used_q) < LIM_W'(INODE_BITS)) ? LIM_W'(inode_used_q)
                                                         : LIM_W'(INODE_BITS);
    end
  end

  assign lim_rnd   = lim + LIM_W'(WORD_BITS - 1);
  assign nwords    = lim_rnd[BIT_W +: WCNT_W];
  assign mark_w    = WCNT_W'(req_idx_q[IDX_W-1:BIT_W]);
  assign word_eff  = ram_rdata;

  assign base = LIM_W'({eval_w_q, {BIT_W{1'b0}}});
  assign rem  = lim - base;

  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      mask[b] = LIM_W'(b) < rem;
    end
  end

  assign free_bits = ~word_eff & mask;

  always_comb begin
    found = 1'b0;
    pos   = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (free_bits[b]) begin
        found = 1'b1;
        pos   = BIT_W'(b);
      end
    end
  end

  assign found_full = base + LIM_W'(pos);
  assign eval_last  = (eval_w_q + WCNT_W'(1)) == nwords;
  assign scan_hit   = eval_v_q && found;
  assign scan_miss  = eval_v_q && !found && eval_last;
  assign issue      = cmd_i.scan_run && (rd_w_q < nwords);

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = phys_addr(req_sel_q, rd_w_q);
    if (cmd_i.mark_rd) begin
      ram_re    = 1'b1;
      ram_raddr = phys_addr(req_sel_q, mark_w);
    end else if (issue) begin
      ram_re = 1'b1;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = phys_addr(req_sel_q, eval_w_q);
    ram_wdata = word_eff | (WORD_BITS'(1) << pos);
    if (cmd_i.clear_run) begin
      ram_we    = 1'b1;
      ram_waddr = clr_w_q;
      ram_wdata = '0;
    end else if (cmd_i.mark_wr) begin
      ram_we    = 1'b1;
      ram_waddr = phys_addr(req_sel_q, mark_w);
      ram_wdata = word_eff | (WORD_BITS'(1) << req_idx_q[BIT_W-1:0]);
    end else if (cmd_i.scan_run && scan_hit && (req_sel_q == MAP_DATA)) begin
      ram_we = 1'b1;
    end
  end

  bffa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (RAM_DEPTH)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inode_used_q <= IREG_W'(INODE_BITS);
      data_used_q  <= DREG_W'(DATA_BITS);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_INODE_BITS: inode_used_q <= cfg_data_i[IREG_W-1:0];
        REG_DATA_BITS:  data_used_q  <= cfg_data_i[DREG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_func_q <= in_user_i[TU_FUNC];
      req_sel_q  <= in_user_i[TU_SEL];
      req_idx_q  <= in_data_i[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_w_q   <= '0;
      eval_w_q <= '0;
      eval_v_q <= 1'b0;
    end else if (cmd_i.capture) begin
      rd_w_q   <= '0;
      eval_v_q <= 1'b0;
    end else if (cmd_i.scan_run) begin
      eval_v_q <= issue;
      eval_w_q <= rd_w_q;
      if (issue) begin
        rd_w_q <= rd_w_q + WCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_w_q <= '0;
    end else if (cmd_i.clear_run) begin
      clr_w_q <= clr_w_q + RAM_AW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pend_range) begin
      pend_st_q  <= ST_RANGE;
      pend_idx_q <= '0;
    end else if (cmd_i.pend_full) begin
      pend_st_q  <= ST_FULL;
      pend_idx_q <= '0;
    end else if (cmd_i.mark_wr) begin
      pend_st_q  <= ST_OK;
      pend_idx_q <= '0;
    end else if (cmd_i.scan_run && scan_hit) begin
      pend_st_q  <= ST_OK;
      pend_idx_q <= found_full[IDX_W-1:0];
    end else if (cmd_i.scan_run && scan_miss) begin
      pend_st_q  <= ST_FULL;
      pend_idx_q <= '0;
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.publish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      out_st_q  <= pend_st_q;
      out_idx_q <= pend_idx_q;
    end
  end

  assign stat_o.clear_done = clr_w_q == RAM_AW'(RAM_DEPTH - 1);
  assign stat_o.is_mark    = req_func_q == FUNC_MARK;
  assign stat_o.idx_ok     = LIM_W'(req_idx_q) < lim;
  assign stat_o.lim_zero   = nwords == '0;
  assign stat_o.scan_done  = scan_hit || scan_miss;
  assign stat_o.out_free   = out_free;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = TDATA_W'(out_idx_q);
  assign out_user_o  = OUT_USER_W'(out_st_q);

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("map RAM read and write hit the same word");

  a_eval_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.scan_run && eval_v_q) |-> (eval_w_q < nwords))
    else $error("scan evaluates a word past the bits in use");

  a_publish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.publish |=> (out_valid_q && out_st_q == $past(pend_st_q)))
    else $error("result lost on publish");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_st_q == ST_OK || out_st_q == ST_FULL || out_st_q == ST_RANGE))
    else $error("undefined status code on output");

  a_found_below_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.scan_run && scan_hit) |-> (found_full < lim))
    else $error("allocated index not below bits in use");

endmodule

>>> rtl/bitmap_first_free_allocator_core.sv
// Top level of the bitmap first-free allocator: controller and datapath.
//
// Requests enter on the s_axis channel: tuser carries the function (allocate
// or mark) and the map select, tdata the bit index to mark. Each request gives
// exactly one result beat on m_axis: tdata the allocated index, tuser the
// status (ok, no free bit, index out of range).
// One request is in service at a time; s_axis_tready is high only when idle.
// A mark reads the addressed map word and writes it back with the bit set. An
// allocate scans one map word per cycle through the single read port of the
// map RAM up to the first word with a free bit, at most ceil(bits_in_use / 32)
// words; a map with no bits in use answers with no free bit without a scan.
// The result register holds a finished beat while m_axis_tready is low; the
// next request is taken as soon as that beat has been loaded, and its result
// waits until the register frees.
// After reset a clearing pass writes zero to all 288 map words, one per cycle,
// with s_axis_tready low until the pass ends; the bit counts load the full
// map sizes.
// Write the count registers through cfg_* only while no request is in flight.
module bitmap_first_free_allocator_core
  import bffa_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [TDATA_W-1:0]    s_axis_tdata,   // [12:0] index, rest zero
  input  logic [IN_USER_W-1:0]  s_axis_tuser,   // [0] func, [1] map_select
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [TDATA_W-1:0]    m_axis_tdata,   // [12:0] alloc_index, rest zero
  output logic [OUT_USER_W-1:0] m_axis_tuser    // [1:0] status
);

  bffa_cmd_t  cmd;
  bffa_stat_t stat;

  bffa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  bffa_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser)
  );

endmodule
